// File: rtl/pfir_pkg.sv
// ----------------------------------------------------------------------------
// pfir_pkg
// Shared constants and types of the parameter file inject receiver.
// ----------------------------------------------------------------------------
package pfir_pkg;

	localparam int DEVICE_ID_BYTES = 5;
	localparam int FILE_CAPACITY   = 65536;
	localparam int SPLIT_MAX       = 1024;

	localparam int HDR_BYTES   = 8;
	localparam int LEN_FIELD_0 = HDR_BYTES + DEVICE_ID_BYTES;
	localparam int ADDR_W      = $clog2(FILE_CAPACITY);
	localparam int CNT_W       = $clog2(FILE_CAPACITY + 1);

	typedef enum logic [7:0] {
		OP_QUERY  = 8'h01,
		OP_SETLEN = 8'h08,
		OP_FRAG   = 8'h09,
		OP_CLEAR  = 8'h0a
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_QUERY_ACK = 2'd0,
		KIND_SUCCESS   = 2'd1,
		KIND_FAILURE   = 2'd2,
		KIND_CLEAR_ALL = 2'd3
	} reply_kind_t;

	typedef enum logic [1:0] {
		ERR_BAD_SUM    = 2'd0,
		ERR_SPLIT      = 2'd1,
		ERR_NO_SPACE   = 2'd2,
		ERR_BAD_LENGTH = 2'd3
	} error_code_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

endpackage

// File: rtl/pfir_ifs.sv
// ----------------------------------------------------------------------------
// pfir_ifs
// Valid/ready channels: received datagram bytes in, replies out.
// ----------------------------------------------------------------------------
interface pfir_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source(output valid, output packet_byte, output last_byte, input ready);
	modport sink(input valid, input packet_byte, input last_byte, output ready);
endinterface

interface pfir_reply_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reply_kind;
	logic [1:0]  error_code;
	logic [15:0] group_id;
	logic        file_complete;
	logic [16:0] file_length;

	modport source(output valid, output reply_kind, output error_code, output group_id,
		output file_complete, output file_length, input ready);
	modport sink(input valid, input reply_kind, input error_code, input group_id,
		input file_complete, input file_length, output ready);
endinterface

// File: rtl/parameter_file_inject_receiver_core.sv
// ----------------------------------------------------------------------------
// parameter_file_inject_receiver_core
// Parses inject datagrams byte by byte, checks checksum and device id, stores
// fragment payload and gives at most one reply per packet.
// ----------------------------------------------------------------------------
//  channel  | dir | words                              | accepted when
//  rx       | in  | packet_byte, last_byte             | valid && ready
//  reply    | out | kind, error, group, complete, len  | valid && ready
//  cfg      | in  | local device id (40 bits)          | cfg_we
//
// One byte is taken each cycle with rx.valid and rx.ready high; the per-byte
// parse is a single pass between the state registers and the reply register.
// A reply appears in the cycle after the last byte of its packet is taken.
// rx.ready drops only while a reply is held and reply.ready is low.
// Reset clears all parse and receive state; the file store is not cleared.
// ----------------------------------------------------------------------------
module parameter_file_inject_receiver_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [39:0]          cfg_wdata,
	pfir_rx_if.sink              rx,
	pfir_reply_if.source         reply
);

	localparam int CW = pfir_pkg::CNT_W;

	logic [39:0]    dev_id_q;
	logic [15:0]    pos_q;
	logic [15:0]    sum_q;
	logic [7:0]     pend_q;
	logic [7:0]     op_q;
	logic [15:0]    hlen_q;
	logic [15:0]    grp_q;
	logic           match_q;
	logic [31:0]    lf_q;
	logic           armed_q;
	logic [CW-1:0]  exp_q;
	logic [CW-1:0]  rc_q;

	logic           rep_valid_q;
	logic [1:0]     rep_kind_q;
	logic [1:0]     rep_err_q;
	logic [15:0]    rep_grp_q;
	logic           rep_done_q;
	logic [16:0]    rep_len_q;

	logic           rx_acc;
	logic           pos_zero;
	logic [15:0]    cur_sum, sum_n, word;
	logic [16:0]    sum_wide;
	logic [7:0]     op_n;
	logic [15:0]    hlen_n, grp_n, pos_n, off;
	logic           match_n, match_f;
	logic [31:0]    lf_n;
	logic [CW:0]    idx;
	logic [15:0]    split;
	logic           split_bad;
	logic [CW:0]    rc_sum;
	logic           armed_n;
	logic [CW-1:0]  exp_n, rc_n;
	logic           emit;
	logic [1:0]     kind_n, err_n;
	logic [15:0]    rgrp_n;
	logic           done_n;
	logic [16:0]    rlen_n;
	pfir_pkg::store_wr_t store_wr;

	function automatic logic [7:0] id_byte(input logic [39:0] id, input int i);
		logic [63:0] wide;
		wide = {24'd0, id};
		return wide[8 * (pfir_pkg::DEVICE_ID_BYTES - 1 - i) +: 8];
	endfunction

	assign rx_acc   = rx.valid && rx.ready;
	assign rx.ready = !rep_valid_q || reply.ready;

	// Per-byte parse. Position zero starts a fresh packet, so the header state
	// is taken as cleared before this byte is applied.
	always_comb begin
		pos_zero = (pos_q == 16'd0);
		cur_sum  = pos_zero ? 16'd0 : sum_q;
		op_n     = pos_zero ? 8'd0 : op_q;
		hlen_n   = pos_zero ? 16'd0 : hlen_q;
		grp_n    = pos_zero ? 16'd0 : grp_q;
		match_n  = pos_zero ? 1'b1 : match_q;
		lf_n     = pos_zero ? 32'd0 : lf_q;

		// Odd positions close a 16-bit word; an odd-length packet pads its last byte.
		word     = pos_q[0] ? {pend_q, rx.packet_byte} : {rx.packet_byte, 8'd0};
		sum_wide = {1'b0, cur_sum} + {1'b0, word};
		if (pos_q[0] || rx.last_byte) begin
			sum_n = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
		end else begin
			sum_n = cur_sum;
		end

		unique case (pos_q)
			16'd1: op_n = rx.packet_byte;
			16'd2: hlen_n[15:8] = rx.packet_byte;
			16'd3: hlen_n[7:0] = rx.packet_byte;
			16'd4: grp_n[15:8] = rx.packet_byte;
			16'd5: grp_n[7:0] = rx.packet_byte;
			default: ;
		endcase

		for (int i = 0; i < pfir_pkg::DEVICE_ID_BYTES; i++) begin
			if (pos_q == 16'(pfir_pkg::HDR_BYTES + i) && id_byte(dev_id_q, i) != rx.packet_byte)
				match_n = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			if (pos_q == 16'(pfir_pkg::LEN_FIELD_0 + k))
				lf_n[8 * (3 - k) +: 8] = lf_n[8 * (3 - k) +: 8] | rx.packet_byte;
		end

		// Byte position saturates at the top, toggling to keep word parity.
		pos_n = (pos_q >= 16'hFFFE) ? (pos_q ^ 16'd1) : (pos_q + 16'd1);

		off  = pos_q - 16'(pfir_pkg::LEN_FIELD_0);
		idx  = (CW+1)'(rc_q) + (CW+1)'(off);
		store_wr.en   = rx_acc && (op_n == pfir_pkg::OP_FRAG) && match_n && armed_q
			&& (pos_q >= 16'(pfir_pkg::LEN_FIELD_0)) && (pos_q < 16'hFFFE)
			&& (off < 16'(pfir_pkg::SPLIT_MAX))
			&& (idx < (CW+1)'(exp_q)) && (idx < (CW+1)'(pfir_pkg::FILE_CAPACITY));
		store_wr.addr = idx[pfir_pkg::ADDR_W-1:0];
		store_wr.data = rx.packet_byte;

		// Id bytes that never arrived compare as zero.
		match_f = match_n;
		for (int i = 0; i < pfir_pkg::DEVICE_ID_BYTES; i++) begin
			if (32'(pfir_pkg::HDR_BYTES + i) > 32'(pos_q) && id_byte(dev_id_q, i) != 8'd0)
				match_f = 1'b0;
		end

		split     = hlen_n - 16'(pfir_pkg::LEN_FIELD_0);
		split_bad = (hlen_n < 16'(pfir_pkg::LEN_FIELD_0))
			|| (split > 16'(pfir_pkg::SPLIT_MAX));
		rc_sum    = (CW+1)'(rc_q) + (CW+1)'(split);

		armed_n = armed_q;
		exp_n   = exp_q;
		rc_n    = rc_q;
		emit    = 1'b0;
		kind_n  = pfir_pkg::KIND_FAILURE;
		err_n   = pfir_pkg::ERR_BAD_SUM;
		rgrp_n  = grp_n;
		done_n  = 1'b0;
		rlen_n  = 17'd0;

		if (sum_n != 16'hFFFF) begin
			emit = 1'b1;
		end else begin
			unique case (op_n)
				pfir_pkg::OP_QUERY: begin
					emit   = 1'b1;
					kind_n = pfir_pkg::KIND_QUERY_ACK;
					rgrp_n = 16'd0;
				end
				pfir_pkg::OP_CLEAR: begin
					emit   = match_f;
					kind_n = pfir_pkg::KIND_CLEAR_ALL;
				end
				pfir_pkg::OP_SETLEN: begin
					if (match_f) begin
						emit = 1'b1;
						rc_n = '0;
						if (lf_n > 32'(pfir_pkg::FILE_CAPACITY)) begin
							armed_n = 1'b0;
							exp_n   = '0;
							err_n   = pfir_pkg::ERR_NO_SPACE;
						end else begin
							armed_n = 1'b1;
							exp_n   = lf_n[CW-1:0];
							kind_n  = pfir_pkg::KIND_SUCCESS;
						end
					end
				end
				pfir_pkg::OP_FRAG: begin
					if (match_f) begin
						emit = 1'b1;
						if (!armed_q) begin
							err_n = pfir_pkg::ERR_BAD_LENGTH;
						end else if (split_bad) begin
							err_n = pfir_pkg::ERR_SPLIT;
						end else if (rc_sum > (CW+1)'(exp_q)) begin
							err_n   = pfir_pkg::ERR_BAD_LENGTH;
							armed_n = 1'b0;
							rc_n    = '0;
						end else if (rc_sum == (CW+1)'(exp_q)) begin
							kind_n  = pfir_pkg::KIND_SUCCESS;
							done_n  = 1'b1;
							rlen_n  = 17'(exp_q);
							armed_n = 1'b0;
							rc_n    = '0;
						end else if (split < 16'(pfir_pkg::SPLIT_MAX)) begin
							err_n   = pfir_pkg::ERR_BAD_LENGTH;
							armed_n = 1'b0;
							rc_n    = '0;
						end else begin
							kind_n = pfir_pkg::KIND_SUCCESS;
							rc_n   = rc_sum[CW-1:0];
						end
					end
				end
				default: ;
			endcase
		end
		if (kind_n != pfir_pkg::KIND_FAILURE)
			err_n = pfir_pkg::ERR_BAD_SUM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q    <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			pend_q      <= '0;
			op_q        <= '0;
			hlen_q      <= '0;
			grp_q       <= '0;
			match_q     <= 1'b1;
			lf_q        <= '0;
			armed_q     <= 1'b0;
			exp_q       <= '0;
			rc_q        <= '0;
			rep_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				dev_id_q <= cfg_wdata;
			if (rx_acc) begin
				sum_q   <= sum_n;
				op_q    <= op_n;
				hlen_q  <= hlen_n;
				grp_q   <= grp_n;
				match_q <= rx.last_byte ? match_f : match_n;
				lf_q    <= lf_n;
				if (!pos_q[0])
					pend_q <= rx.packet_byte;
				if (rx.last_byte) begin
					pos_q   <= '0;
					armed_q <= armed_n;
					exp_q   <= exp_n;
					rc_q    <= rc_n;
				end else begin
					pos_q <= pos_n;
				end
			end
			if (rx_acc && rx.last_byte && emit)
				rep_valid_q <= 1'b1;
			else if (reply.ready)
				rep_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc && rx.last_byte && emit) begin
			rep_kind_q <= kind_n;
			rep_err_q  <= err_n;
			rep_grp_q  <= rgrp_n;
			rep_done_q <= done_n;
			rep_len_q  <= rlen_n;
		end
	end

	assign reply.valid         = rep_valid_q;
	assign reply.reply_kind    = rep_kind_q;
	assign reply.error_code    = rep_err_q;
	assign reply.group_id      = rep_grp_q;
	assign reply.file_complete = rep_done_q;
	assign reply.file_length   = rep_len_q;

	pfir_file_store u_store (
		.clk (clk),
		.wr  (store_wr)
	);

`ifndef NO_ASSERTIONS
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && rx.last_byte) |=> (pos_q == 16'd0))
		else $error("byte position not restarted after last byte");

	a_reply_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rep_valid_q) |-> $past(rx_acc && rx.last_byte))
		else $error("reply raised without a finished packet");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= exp_q)
		else $error("received count beyond expected length");

	a_disarmed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (rc_q == '0))
		else $error("received count kept while not armed");

	a_hold_stalls_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_valid_q && !reply.ready) |-> !rx.ready)
		else $error("byte taken while a reply is stalled");
`endif

endmodule

// File: rtl/pfir_file_store.sv
// ----------------------------------------------------------------------------
// pfir_file_store
// Byte store that collects the fragment payload of the parameter file.
// ----------------------------------------------------------------------------
module pfir_file_store (
	input  logic                clk,
	input  pfir_pkg::store_wr_t wr
);

	logic [7:0] mem [pfir_pkg::FILE_CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

endmodule
